/* sv/dhmt_pkg.sv */
// Shared types and codes of the detector hit merge table.
package dhmt_pkg;

	typedef enum logic [1:0] {
		CMD_HIT   = 2'd0,
		CMD_DUMP  = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IGNORED    = 3'd0,
		ST_INSERTED   = 3'd1,
		ST_MERGED     = 3'd2,
		ST_DROPPED    = 3'd3,
		ST_DUMP_ENTRY = 3'd4,
		ST_DUMP_EMPTY = 3'd5,
		ST_CLEARED    = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_SEARCH,
		FSM_EXEC,
		FSM_DUMP
	} fsm_t;

	// one table entry, first field in the highest bits
	typedef struct packed {
		logic [31:0] interaction_time;
		logic [47:0] polarization;
		logic [47:0] direction;
		logic [24:0] residual;
		logic [23:0] deposit;
		logic [31:0] local_time;
		logic [31:0] event_id;
		logic [9:0]  scintillator_id;
	} entry_t;

	typedef struct packed {
		logic load;
		logic merge;
		logic shift;
	} cell_ctl_t;

	localparam int unsigned EntryBits = $bits(entry_t);

endpackage

/* sv/dhmt_cell.sv */
// One table cell: holds an entry, compares it with a hit, merges, loads or shifts.
module dhmt_cell (
	input  logic                clk,
	input  dhmt_pkg::cell_ctl_t ctl,
	input  dhmt_pkg::entry_t    hit,
	input  logic [31:0]         time_window,
	input  dhmt_pkg::entry_t    nbr,
	output dhmt_pkg::entry_t    entry,
	output logic                match,
	output logic                in_window
);
	dhmt_pkg::entry_t entry_q;
	dhmt_pkg::entry_t merged;
	logic [31:0] diff;
	logic [24:0] loss_sum;
	logic [25:0] after_dif;
	logic [32:0] it_sum;

	always_comb begin
		diff = (entry_q.local_time >= hit.local_time) ?
			entry_q.local_time - hit.local_time : hit.local_time - entry_q.local_time;
		match     = (entry_q.scintillator_id == hit.scintillator_id);
		in_window = (diff <= time_window);

		loss_sum  = {1'b0, entry_q.deposit} + {1'b0, hit.deposit};
		after_dif = {entry_q.residual[24], entry_q.residual} - {2'b00, hit.deposit};
		it_sum    = {1'b0, entry_q.interaction_time} + {1'b0, hit.interaction_time};

		merged                  = entry_q;
		merged.deposit          = loss_sum[24] ? 24'hFFFFFF : loss_sum[23:0];
		// clamp at the most negative 25-bit value
		merged.residual         = (after_dif[25] != after_dif[24]) ? 25'h1000000 : after_dif[24:0];
		merged.direction        = hit.direction;
		merged.polarization     = hit.polarization;
		merged.interaction_time = it_sum[32] ? 32'hFFFFFFFF : it_sum[31:0];
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			entry_q <= nbr;
		end else if (ctl.load) begin
			entry_q <= hit;
		end else if (ctl.merge) begin
			entry_q <= merged;
		end
	end

	assign entry = entry_q;

endmodule

/* sv/detector_hit_merge_table_unit.sv */
// Top level of the detector hit merge table: command decode, cell row and result register.
// A hit, clear or unused command is captured, then compared in parallel in every cell with
// the match registered, then picked and written with its result beat registered, waiting
// while the output stalls; the input takes a new beat only once the block is back in idle.
// A dump rotates the whole cell row once, emitting one beat per valid entry; a valid entry
// at the bottom cell holds the rotation while the output stalls.
// Reset (arst_n low, asynchronous) empties the table and clears the window register;
// entry contents are not cleared and are never read before they are written.
module detector_hit_merge_table_unit #(
	parameter int unsigned TABLE_DEPTH = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	// configuration: time_window
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [31:0]  cfg_data,
	// input beats
	input  logic         s_tvalid,
	output logic         s_tready,
	// from_source[0], event_id[32:1], scintillator_id[42:33], local_time[74:43],
	// deposit[98:75], residual[123:99], direction[171:124],
	// polarization[219:172], interaction_time[251:220], zero fill above
	input  logic [255:0] s_tdata,
	// cmd[1:0]
	input  logic [1:0]   s_tuser,
	// result beats
	output logic         m_tvalid,
	input  logic         m_tready,
	// out_scintillator[9:0], out_event[41:10], out_time[73:42], out_energy_loss[97:74],
	// out_energy_after[122:98], out_direction[170:123], out_polarization[218:171],
	// out_interaction_time[250:219], zero fill above
	output logic [255:0] m_tdata,
	// status[2:0]
	output logic [2:0]   m_tuser,
	output logic         m_tlast
);
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	dhmt_pkg::fsm_t state_q, state_d;

	logic [31:0]       window_q;
	logic [CW-1:0]     count_q, count_d;
	logic [CW-1:0]     dcnt_q, dcnt_d;
	dhmt_pkg::entry_t  hit_q;
	dhmt_pkg::cmd_t    cmd_q;
	logic              src_q;

	logic [TABLE_DEPTH-1:0] match_s1, inwin_s1;
	logic [TABLE_DEPTH-1:0] match_c, inwin_c;
	dhmt_pkg::entry_t       cell_entry [TABLE_DEPTH];
	dhmt_pkg::cell_ctl_t    cell_ctl   [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] merge_vec, load_vec;
	logic                   shift_all;

	logic              m_tvalid_q, m_tlast_q;
	dhmt_pkg::status_t m_status_q;
	dhmt_pkg::entry_t  m_entry_q;

	logic              emit;
	logic              emit_last;
	dhmt_pkg::status_t emit_status;
	logic              emit_entry;
	logic              out_free;
	logic              found;
	logic [IW-1:0]     found_idx;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == dhmt_pkg::FSM_IDLE);
	assign out_free  = !m_tvalid_q || m_tready;

	// the row of cells; during a dump each one takes its upper neighbor, the top wraps to 0
	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
		dhmt_cell u_cell (
			.clk         (clk),
			.ctl         (cell_ctl[g]),
			.hit         (hit_q),
			.time_window (window_q),
			.nbr         (cell_entry[(g + 1) % TABLE_DEPTH]),
			.entry       (cell_entry[g]),
			.match       (match_c[g]),
			.in_window   (inwin_c[g])
		);
		assign cell_ctl[g] = '{load: load_vec[g], merge: merge_vec[g], shift: shift_all};
	end

	// pick the newest valid entry of the same scintillator
	always_comb begin
		found     = 1'b0;
		found_idx = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (match_s1[i]) begin
				found     = 1'b1;
				found_idx = IW'(i);
			end
		end
	end

	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		dcnt_d      = dcnt_q;
		merge_vec   = '0;
		load_vec    = '0;
		shift_all   = 1'b0;
		emit        = 1'b0;
		emit_last   = 1'b1;
		emit_entry  = 1'b0;
		emit_status = dhmt_pkg::ST_IGNORED;
		unique case (state_q)
			dhmt_pkg::FSM_IDLE: begin
				if (s_tvalid) begin
					state_d = dhmt_pkg::FSM_SEARCH;
				end
			end
			dhmt_pkg::FSM_SEARCH: begin
				state_d = dhmt_pkg::FSM_EXEC;
			end
			dhmt_pkg::FSM_EXEC: begin
				if (out_free) begin
					state_d = dhmt_pkg::FSM_IDLE;
					emit    = 1'b1;
					case (cmd_q)
						dhmt_pkg::CMD_DUMP: begin
							if (count_q == '0) begin
								emit_status = dhmt_pkg::ST_DUMP_EMPTY;
							end else begin
								emit    = 1'b0;
								dcnt_d  = '0;
								state_d = dhmt_pkg::FSM_DUMP;
							end
						end
						dhmt_pkg::CMD_CLEAR: begin
							count_d     = '0;
							emit_status = dhmt_pkg::ST_CLEARED;
						end
						dhmt_pkg::CMD_HIT: begin
							if (!src_q) begin
								emit_status = dhmt_pkg::ST_IGNORED;
							end else if (found && inwin_s1[found_idx]) begin
								merge_vec[found_idx] = 1'b1;
								emit_status          = dhmt_pkg::ST_MERGED;
							end else if (count_q >= CW'(TABLE_DEPTH)) begin
								emit_status = dhmt_pkg::ST_DROPPED;
							end else begin
								load_vec[count_q[IW-1:0]] = 1'b1;
								count_d                   = count_q + 1'b1;
								emit_status               = dhmt_pkg::ST_INSERTED;
							end
						end
						default: begin
							emit_status = dhmt_pkg::ST_IGNORED;
						end
					endcase
				end
			end
			dhmt_pkg::FSM_DUMP: begin
				// advance the rotation; a valid entry at the bottom cell waits for the output
				if (dcnt_q >= count_q || out_free) begin
					shift_all = 1'b1;
					dcnt_d    = dcnt_q + 1'b1;
					if (dcnt_q < count_q) begin
						emit        = 1'b1;
						emit_entry  = 1'b1;
						emit_status = dhmt_pkg::ST_DUMP_ENTRY;
						emit_last   = (dcnt_q == count_q - 1'b1);
					end
					if (dcnt_q == CW'(TABLE_DEPTH - 1)) begin
						state_d = dhmt_pkg::FSM_IDLE;
					end
				end
			end
			default: begin
				state_d = dhmt_pkg::FSM_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= dhmt_pkg::FSM_IDLE;
			count_q    <= '0;
			dcnt_q     <= '0;
			window_q   <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			dcnt_q  <= dcnt_d;
			if (cfg_valid) begin
				window_q <= cfg_data;
			end
			if (emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// capture the beat, then register the per-cell compare masked by fill level
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_q                  <= dhmt_pkg::cmd_t'(s_tuser);
			src_q                  <= s_tdata[0];
			hit_q.event_id         <= s_tdata[32:1];
			hit_q.scintillator_id  <= s_tdata[42:33];
			hit_q.local_time       <= s_tdata[74:43];
			hit_q.deposit          <= s_tdata[98:75];
			hit_q.residual         <= s_tdata[123:99];
			hit_q.direction        <= s_tdata[171:124];
			hit_q.polarization     <= s_tdata[219:172];
			hit_q.interaction_time <= s_tdata[251:220];
		end
		if (state_q == dhmt_pkg::FSM_SEARCH) begin
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				match_s1[i] <= match_c[i] && (CW'(i) < count_q);
			end
			inwin_s1 <= inwin_c;
		end
		if (emit) begin
			m_status_q <= emit_status;
			m_tlast_q  <= emit_last;
			m_entry_q  <= emit_entry ? cell_entry[0] : '0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_status_q;
	assign m_tlast  = m_tlast_q;
	assign m_tdata  = {{(256 - dhmt_pkg::EntryBits){1'b0}}, m_entry_q};

	// fill level never passes the row length
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	// at most one cell merges in a cycle
	a_merge_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(merge_vec))
		else $error("several cells merged at once");

	// a cell never loads and merges together, nor during a rotation
	a_write_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!((|merge_vec) && (|load_vec)) && !(shift_all && ((|merge_vec) || (|load_vec))))
		else $error("conflicting cell writes");

	// a dump leaves the fill level alone
	a_dump_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dhmt_pkg::FSM_DUMP) |=> $stable(count_q))
		else $error("fill level changed during dump");

endmodule
